// File: rtl/vis_pkg.sv
// ----------------------------------------------------------------------------
// vis_pkg
// Shared types and constants of the viscous stress update block.
// ----------------------------------------------------------------------------
package vis_pkg;

    localparam int POINTS    = 1024;
    localparam int IDX_W     = $clog2(POINTS);
    localparam int FRAC_BITS = 16;
    localparam int LANES     = 6;
    localparam int NORMALS   = 3;
    localparam int DIV_STEPS = 32;
    localparam int DEN_W     = 47;
    localparam int ROW_W     = 32 * LANES;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_LAMBDA = 2'd0,
        CFG_MU     = 2'd1,
        CFG_RELAX  = 2'd2,
        CFG_STEP   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [9:0]         point_index;
        logic signed [31:0] grad_xx;
        logic signed [31:0] grad_xy;
        logic signed [31:0] grad_xz;
        logic signed [31:0] grad_yx;
        logic signed [31:0] grad_yy;
        logic signed [31:0] grad_yz;
        logic signed [31:0] grad_zx;
        logic signed [31:0] grad_zy;
        logic signed [31:0] grad_zz;
    } in_t;

    typedef struct packed {
        logic signed [31:0] new_xx;
        logic signed [31:0] new_yy;
        logic signed [31:0] new_zz;
        logic signed [31:0] new_xy;
        logic signed [31:0] new_xz;
        logic signed [31:0] new_yz;
        logic               saturated;
    } out_t;

    // sideband that travels with a transaction through the divider
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             sat;
        logic [LANES-1:0] neg;
        logic [LANES-1:0] big;
    } div_tag_t;

    // one divider lane: partial remainder and shared dividend/quotient word
    typedef struct packed {
        logic [DEN_W-1:0]     rem;
        logic [DIV_STEPS-1:0] word;
    } div_lane_t;

endpackage

// File: rtl/viscoelastic_internal_stress_update.sv
// ----------------------------------------------------------------------------
// viscoelastic_internal_stress_update
// Maxwell viscous stress update per integration point, stored on chip.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_data) carries one point index and
// its 3x3 displacement gradient. Output channel (out_valid / out_stall /
// out_data) returns the six updated stress components and a clip flag.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write
// it only while no transaction is in flight.
// Throughput: one transaction per cycle while no receiver stall, clearing
// pass or point hazard stalls the input. The pipeline has 11 arithmetic
// stages, 32 divider stages and an output register. The divider pipeline,
// one quotient bit per stage, sets the latency. Stress rows live in a
// 1024 x 192-bit memory, read at the idx_reg[6] index ahead of the add stage
// and written back as the result leaves. A point already in flight holds
// the input stalled until its write-back.
// After reset a clearing pass writes zero to every row while in_stall stays
// high. When the receiver stalls, the whole pipeline holds and the input is
// stalled too.
// ----------------------------------------------------------------------------
module viscoelastic_internal_stress_update (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  vis_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output vis_pkg::out_t  out_data,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_data
);
    import vis_pkg::*;

    localparam int NSTG  = 11;
    localparam int STG_G = 6;
    localparam int STG_K = 10;
    localparam logic [62:0] INTER_MAX = {1'b0, {62{1'b1}}};
    localparam int RND   = 1 << (FRAC_BITS - 1);

    // configuration
    logic signed [31:0] lambda_reg, mu_reg;
    logic [30:0]        relax_reg, step_reg;
    logic [61:0]        dprod_reg;
    logic [DEN_W-1:0]   den_reg;

    // control
    logic             adv, accept, hazard, clearing, probe_hit;
    logic [IDX_W:0]   clr_cnt_reg;
    logic             v_reg   [NSTG];
    logic [IDX_W-1:0] idx_reg [NSTG];

    // arithmetic stages
    logic signed [32:0] a_e2_reg [LANES];
    logic signed [33:0] a_tr_reg;
    logic signed [32:0] e2_next [LANES];
    logic signed [33:0] tr_next;
    logic [64:0]        b_pm_reg [LANES];
    logic               b_pmn_reg [LANES];
    logic [64:0]        b_pl_reg;
    logic               b_pln_reg;
    logic signed [50:0] c_pm_reg [LANES];
    logic signed [50:0] c_pl_reg;
    logic signed [51:0] d_t_reg [LANES];
    logic [50:0]        e_m_reg [LANES];
    logic               e_n_reg [LANES];
    logic [56:0]        f_lo_reg [LANES];
    logic [56:0]        f_hi_reg [LANES];
    logic               f_n_reg [LANES];
    logic [81:0]        g_p_reg [LANES];
    logic               g_n_reg [LANES];
    logic [61:0]        h_m_reg [LANES];
    logic               h_n_reg [LANES];
    logic               h_sat_reg;
    logic signed [63:0] i_n_reg [LANES];
    logic               i_sat_reg;
    logic [62:0]        j_m_reg [LANES];
    logic               j_n_reg [LANES];
    logic               j_sat_reg;
    div_tag_t           k_tag_reg;
    div_lane_t          k_lane_reg [LANES];
    logic [ROW_W-1:0]   rdata_reg;

    // divider outputs and write-back
    logic               dv_valid;
    div_tag_t           dv_tag;
    div_lane_t          dv_lane [LANES];
    logic [31:0]        res [LANES];
    logic               res_sat;
    logic [ROW_W-1:0]   res_row;
    out_t               out_reg;
    logic               out_valid_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    logic [ROW_W-1:0]   mem_wd;
    logic [ROW_W-1:0]   mem [POINTS];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lambda_reg <= '0;
            mu_reg     <= '0;
            relax_reg  <= '0;
            step_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LAMBDA: lambda_reg <= cfg_data;
                CFG_MU:     mu_reg     <= cfg_data;
                CFG_RELAX:  relax_reg  <= cfg_data[30:0];
                CFG_STEP:   step_reg   <= cfg_data[30:0];
                default:    ;
            endcase
        end
    end

    // form the divisor from the current configuration
    always_ff @(posedge clk)
    begin
        dprod_reg <= 62'(relax_reg) * 62'(step_reg);
        den_reg   <= DEN_W'(1 << FRAC_BITS)
                   + DEN_W'((63'(dprod_reg) + 63'(RND)) >> FRAC_BITS);
    end

    // handshake and interlock
    assign adv      = !out_valid_reg || !out_stall;
    assign clearing = (clr_cnt_reg < (IDX_W + 1)'(POINTS));

    always_comb
    begin
        hazard = probe_hit;
        for (int s = 0; s < NSTG; s++)
            if (v_reg[s] && (idx_reg[s] == in_data.point_index[IDX_W-1:0]))
                hazard = 1'b1;
    end

    assign in_stall = !adv || clearing || hazard;
    assign accept   = in_valid && !in_stall;

    // advance clearing counter and stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            for (int s = 0; s < NSTG; s++)
                v_reg[s] <= 1'b0;
        end
        else
        begin
            if (clearing)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (adv)
            begin
                v_reg[0] <= accept;
                for (int s = 1; s < NSTG; s++)
                    v_reg[s] <= v_reg[s-1];
            end
        end
    end

    // strain and trace
    always_comb
    begin
        e2_next[0] = {in_data.grad_xx, 1'b0};
        e2_next[1] = {in_data.grad_yy, 1'b0};
        e2_next[2] = {in_data.grad_zz, 1'b0};
        e2_next[3] = 33'(in_data.grad_xy) + 33'(in_data.grad_yx);
        e2_next[4] = 33'(in_data.grad_xz) + 33'(in_data.grad_zx);
        e2_next[5] = 33'(in_data.grad_yz) + 33'(in_data.grad_zy);
        tr_next    = 34'(in_data.grad_xx) + 34'(in_data.grad_yy) + 34'(in_data.grad_zz);
    end

    // arithmetic pipeline
    always_ff @(posedge clk)
    begin
        logic [32:0] me;
        logic [31:0] mm, ml;
        logic [32:0] mt;
        logic [65:0] rs;
        logic [82:0] ps;
        logic [66:0] pr;
        logic        hs;
        if (adv)
        begin
            idx_reg[0] <= in_data.point_index[IDX_W-1:0];
            for (int s = 1; s < NSTG; s++)
                idx_reg[s] <= idx_reg[s-1];
            for (int l = 0; l < LANES; l++)
                a_e2_reg[l] <= e2_next[l];
            a_tr_reg <= tr_next;

            // magnitude products
            mm = mu_reg[31] ? 32'(-mu_reg) : 32'(mu_reg);
            ml = lambda_reg[31] ? 32'(-lambda_reg) : 32'(lambda_reg);
            for (int l = 0; l < LANES; l++)
            begin
                me = a_e2_reg[l][32] ? 33'(-a_e2_reg[l]) : 33'(a_e2_reg[l]);
                b_pm_reg[l]  <= 65'(me) * 65'(mm);
                b_pmn_reg[l] <= a_e2_reg[l][32] ^ mu_reg[31];
            end
            mt = a_tr_reg[33] ? 33'(-a_tr_reg) : 33'(a_tr_reg);
            b_pl_reg  <= 65'(mt) * 65'(ml);
            b_pln_reg <= a_tr_reg[33] ^ lambda_reg[31];

            // round half away from zero and restore sign
            for (int l = 0; l < LANES; l++)
            begin
                rs = {1'b0, b_pm_reg[l]} + 66'(RND);
                c_pm_reg[l] <= b_pmn_reg[l] ? -$signed({1'b0, rs[65:16]})
                                            :  $signed({1'b0, rs[65:16]});
            end
            rs = {1'b0, b_pl_reg} + 66'(RND);
            c_pl_reg <= b_pln_reg ? -$signed({1'b0, rs[65:16]})
                                  :  $signed({1'b0, rs[65:16]});

            // rate term
            for (int l = 0; l < LANES; l++)
            begin
                if (l < NORMALS)
                    d_t_reg[l] <= -52'(c_pm_reg[l]) - 52'(c_pl_reg);
                else
                    d_t_reg[l] <= -52'(c_pm_reg[l]);
            end

            // split magnitude for the time step product
            for (int l = 0; l < LANES; l++)
            begin
                e_m_reg[l] <= d_t_reg[l][51] ? 51'(-d_t_reg[l]) : 51'(d_t_reg[l]);
                e_n_reg[l] <= d_t_reg[l][51];
            end

            for (int l = 0; l < LANES; l++)
            begin
                f_lo_reg[l] <= 57'(step_reg) * 57'(e_m_reg[l][25:0]);
                f_hi_reg[l] <= 57'(step_reg) * 57'(e_m_reg[l][50:26]);
                f_n_reg[l]  <= e_n_reg[l];
            end

            for (int l = 0; l < LANES; l++)
            begin
                g_p_reg[l] <= 82'(f_lo_reg[l]) + (82'(f_hi_reg[l]) << 26);
                g_n_reg[l] <= f_n_reg[l];
            end

            // round and clip the time step product
            hs = 1'b0;
            for (int l = 0; l < LANES; l++)
            begin
                ps = {1'b0, g_p_reg[l]} + 83'(RND);
                pr = ps[82:16];
                if (pr > 67'(INTER_MAX))
                begin
                    h_m_reg[l] <= INTER_MAX[61:0];
                    hs = 1'b1;
                end
                else
                begin
                    h_m_reg[l] <= pr[61:0];
                end
                h_n_reg[l] <= g_n_reg[l];
            end
            h_sat_reg <= hs;

            // add stored stress
            for (int l = 0; l < LANES; l++)
                i_n_reg[l] <= (h_n_reg[l] ? -$signed(64'(h_m_reg[l]))
                                          :  $signed(64'(h_m_reg[l])))
                            + 64'($signed(rdata_reg[32*l +: 32]));
            i_sat_reg <= h_sat_reg;

            for (int l = 0; l < LANES; l++)
            begin
                j_m_reg[l] <= i_n_reg[l][63] ? 63'(-i_n_reg[l]) : 63'(i_n_reg[l]);
                j_n_reg[l] <= i_n_reg[l][63];
            end
            j_sat_reg <= i_sat_reg;

            // overflow check and divider set-up
            k_tag_reg.idx <= idx_reg[STG_K-1];
            k_tag_reg.sat <= j_sat_reg;
            for (int l = 0; l < LANES; l++)
            begin
                k_tag_reg.neg[l] <= j_n_reg[l];
                if (j_m_reg[l] >= {den_reg, {FRAC_BITS{1'b0}}})
                begin
                    k_tag_reg.big[l]   <= 1'b1;
                    k_lane_reg[l].rem  <= '0;
                end
                else
                begin
                    k_tag_reg.big[l]   <= 1'b0;
                    k_lane_reg[l].rem  <= j_m_reg[l][62:16];
                end
                k_lane_reg[l].word <= {j_m_reg[l][15:0], {FRAC_BITS{1'b0}}};
            end
        end
    end

    vis_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v_reg[STG_K]),
        .in_tag    (k_tag_reg),
        .in_lane   (k_lane_reg),
        .den       (den_reg),
        .probe_idx (in_data.point_index[IDX_W-1:0]),
        .probe_hit (probe_hit),
        .out_valid (dv_valid),
        .out_tag   (dv_tag),
        .out_lane  (dv_lane)
    );

    // round quotient and saturate
    always_comb
    begin
        logic        rnd;
        logic [32:0] q;
        res_sat = dv_tag.sat;
        for (int l = 0; l < LANES; l++)
        begin
            rnd = ({dv_lane[l].rem, 1'b0} >= {1'b0, den_reg});
            q   = {1'b0, dv_lane[l].word} + 33'(rnd);
            if (dv_tag.neg[l])
            begin
                if (dv_tag.big[l] || (q > 33'h0_8000_0000))
                begin
                    res[l]  = 32'h8000_0000;
                    res_sat = 1'b1;
                end
                else
                begin
                    res[l] = 32'(-q);
                end
            end
            else
            begin
                if (dv_tag.big[l] || (q > 33'h0_7FFF_FFFF))
                begin
                    res[l]  = 32'h7FFF_FFFF;
                    res_sat = 1'b1;
                end
                else
                begin
                    res[l] = q[31:0];
                end
            end
            res_row[32*l +: 32] = res[l];
        end
    end

    // stress memory: clearing pass, write-back, read ahead of the add stage
    assign mem_we = clearing || (adv && dv_valid);
    assign mem_wa = clearing ? clr_cnt_reg[IDX_W-1:0] : dv_tag.idx;
    assign mem_wd = clearing ? '0 : res_row;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (adv)
            rdata_reg <= mem[idx_reg[STG_G]];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.new_xx    <= res[0];
            out_reg.new_yy    <= res[1];
            out_reg.new_zz    <= res[2];
            out_reg.new_xy    <= res[3];
            out_reg.new_xz    <= res[4];
            out_reg.new_yz    <= res[5];
            out_reg.saturated <= res_sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: rtl/vis_div.sv
// ----------------------------------------------------------------------------
// vis_div
// Six-lane restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module vis_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    in_valid,
    input  vis_pkg::div_tag_t       in_tag,
    input  vis_pkg::div_lane_t      in_lane [vis_pkg::LANES],
    input  logic [vis_pkg::DEN_W-1:0] den,
    input  logic [vis_pkg::IDX_W-1:0] probe_idx,
    output logic                    probe_hit,
    output logic                    out_valid,
    output vis_pkg::div_tag_t       out_tag,
    output vis_pkg::div_lane_t      out_lane [vis_pkg::LANES]
);
    import vis_pkg::*;

    logic      v_reg    [DIV_STEPS];
    div_tag_t  tag_reg  [DIV_STEPS];
    div_lane_t lane_reg [DIV_STEPS][LANES];
    div_lane_t lane_next [DIV_STEPS][LANES];

    function automatic div_lane_t div_step(div_lane_t x, logic [DEN_W-1:0] d);
        logic [DEN_W:0] r;
        logic           qb;
        div_lane_t      y;
        r  = {x.rem, x.word[DIV_STEPS-1]};
        qb = (r >= {1'b0, d});
        if (qb)
        begin
            r = r - {1'b0, d};
        end
        y.rem  = r[DEN_W-1:0];
        y.word = {x.word[DIV_STEPS-2:0], qb};
        return y;
    endfunction

    // one subtract-and-compare per stage
    always_comb
    begin
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (s == 0)
                    lane_next[s][l] = div_step(in_lane[l], den);
                else
                    lane_next[s][l] = div_step(lane_reg[s-1][l], den);
            end
        end
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_STEPS; s++)
                v_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < DIV_STEPS; s++)
                v_reg[s] <= v_reg[s-1];
        end
    end

    // advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag_reg[0] <= in_tag;
            for (int s = 1; s < DIV_STEPS; s++)
                tag_reg[s] <= tag_reg[s-1];
            for (int s = 0; s < DIV_STEPS; s++)
                for (int l = 0; l < LANES; l++)
                    lane_reg[s][l] <= lane_next[s][l];
        end
    end

    // look up points still in flight
    always_comb
    begin
        probe_hit = 1'b0;
        for (int s = 0; s < DIV_STEPS; s++)
            if (v_reg[s] && (tag_reg[s].idx == probe_idx))
                probe_hit = 1'b1;
    end

    assign out_valid = v_reg[DIV_STEPS-1];
    assign out_tag   = tag_reg[DIV_STEPS-1];
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            out_lane[l] = lane_reg[DIV_STEPS-1][l];
    end

endmodule

// File: rtl/vis_checker.sv
// ----------------------------------------------------------------------------
// vis_checker
// Port-level checks of the viscous stress update block.
// ----------------------------------------------------------------------------
module vis_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_stall,
    input vis_pkg::in_t  in_data,
    input logic          out_valid,
    input logic          out_stall,
    input vis_pkg::out_t out_data
);
    import vis_pkg::*;

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // a waiting result holds the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input accepted while result stalled");

    // clearing pass blocks input right after reset
    assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> in_stall)
        else $error("input accepted during clearing pass");

    // same point never accepted twice in a row
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=>
        !(in_valid && !in_stall &&
          in_data.point_index == $past(in_data.point_index)))
        else $error("back to back transaction on one point");

endmodule

bind viscoelastic_internal_stress_update vis_checker u_vis_checker (.*);
